FILE: sv/qte_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the quaternion to Euler angle block.
// No dependencies.
package qte_pkg;

    localparam int CORDIC_STAGES_DEF   = 20;
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    localparam int QW  = 32;   // quaternion component width
    localparam int PW  = 34;   // Q30 product width
    localparam int SW  = 38;   // sum / numerator / denominator width
    localparam int XW  = 40;   // CORDIC x and y width
    localparam int ZW  = 36;   // CORDIC angle width
    localparam int RW  = 64;   // square root working width
    localparam int SQRT_STEPS = 32;
    localparam int PITCH_W = 16;
    localparam int ROLL_W  = 17;
    localparam int YAW_W   = 17;

    localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;

    typedef struct packed {
        logic                 done;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cord;

    typedef struct packed {
        logic [RW-1:0] v;
        logic [RW-1:0] res;
    } t_sqrt;

    // atan(2^-i) in Q30, rounded to nearest
    function automatic logic [30:0] atan_q30(input int idx);
        logic [30:0] r;
        unique case (idx)
            0:  r = 31'd843314857;
            1:  r = 31'd497837829;
            2:  r = 31'd263043837;
            3:  r = 31'd133525159;
            4:  r = 31'd67021687;
            5:  r = 31'd33543516;
            6:  r = 31'd16775851;
            7:  r = 31'd8388437;
            8:  r = 31'd4194283;
            9:  r = 31'd2097149;
            10: r = 31'd1048576;
            11: r = 31'd524288;
            12: r = 31'd262144;
            13: r = 31'd131072;
            14: r = 31'd65536;
            15: r = 31'd32768;
            16: r = 31'd16384;
            17: r = 31'd8192;
            18: r = 31'd4096;
            19: r = 31'd2048;
            20: r = 31'd1024;
            21: r = 31'd512;
            22: r = 31'd256;
            23: r = 31'd128;
            24: r = 31'd64;
            25: r = 31'd32;
            26: r = 31'd16;
            27: r = 31'd8;
            28: r = 31'd4;
            29: r = 31'd2;
            30: r = 31'd1;
            default: r = 31'd0;
        endcase
        return r;
    endfunction

    // product of two Q30 values, floor-shifted back to Q30
    function automatic logic signed [PW-1:0] mul_q30(input logic signed [QW-1:0] a,
                                                     input logic signed [QW-1:0] b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        return p[2*QW-1:30];
    endfunction

    // fold the left half-plane onto the right and catch a zero numerator
    function automatic t_cord cord_pre(input logic signed [XW-1:0] y,
                                       input logic signed [XW-1:0] x);
        t_cord c;
        c.done = (y == '0);
        c.x    = x;
        c.y    = y;
        c.z    = '0;
        if (c.done) begin
            c.z = (x < 0) ? PI_Q30 : '0;
        end else if (x < 0) begin
            c.z = (y > 0) ? PI_Q30 : -PI_Q30;
            c.x = -x;
            c.y = -y;
        end
        return c;
    endfunction

endpackage

FILE: sv/qte_sqrt_cell.sv
`timescale 1ns / 1ps
// One step of the digit-by-digit integer square root, registered.
// Uses qte_pkg.
module qte_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  qte_pkg::t_sqrt i_d,
    output qte_pkg::t_sqrt o_q
);
    localparam logic [qte_pkg::RW-1:0] BIT = 64'd1 << (62 - 2 * STEP);

    qte_pkg::t_sqrt r_q, n_q;
    logic [qte_pkg::RW-1:0] trial;

    always_comb begin
        trial = i_d.res + BIT;
        n_q   = i_d;
        if (i_d.v >= trial) begin
            n_q.v   = i_d.v - trial;
            n_q.res = (i_d.res >> 1) + BIT;
        end else begin
            n_q.res = i_d.res >> 1;
        end
    end

    // advance with the pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

FILE: sv/qte_cordic_cell.sv
`timescale 1ns / 1ps
// One vectoring CORDIC rotation, registered.
// Uses qte_pkg.
module qte_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  qte_pkg::t_cord i_d,
    output qte_pkg::t_cord o_q
);
    qte_pkg::t_cord r_q, n_q;
    logic signed [qte_pkg::XW-1:0] x, y, dx, dy;
    logic signed [qte_pkg::ZW-1:0] z, da;

    always_comb begin
        x   = i_d.x;
        y   = i_d.y;
        z   = i_d.z;
        dx  = y >>> STEP;
        dy  = x >>> STEP;
        da  = $signed({{(qte_pkg::ZW - 31){1'b0}}, qte_pkg::atan_q30(STEP)});
        n_q = i_d;
        // hold a result already settled by the zero-numerator case
        if (!i_d.done) begin
            if (y > 0) begin
                n_q.x = x + dx;
                n_q.y = y - dy;
                n_q.z = z + da;
            end else begin
                n_q.x = x - dx;
                n_q.y = y + dy;
                n_q.z = z - da;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

FILE: sv/qte_scale.sv
`timescale 1ns / 1ps
// Radians Q30 to degrees in 2^-FRAC units: three registered stages, then saturation.
// Uses qte_pkg.
module qte_scale #(
    parameter int FRAC  = qte_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int OUT_W = qte_pkg::PITCH_W
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [qte_pkg::ZW-1:0] i_z,
    output logic signed [OUT_W-1:0]       o_angle
);
    localparam logic [28:0] HI = 29'((1 << (OUT_W - 1)) - 1);

    logic        r_neg_a, r_neg_b, r_neg_c;
    logic [45:0] r_p;
    logic [31:0] r_t;
    logic [28:0] r_q;
    logic [qte_pkg::ZW-1:0] mag;
    logic [63:0] sum, t_full, prod;
    logic [29:0] q_s;

    always_comb begin
        mag    = (i_z < 0) ? qte_pkg::ZW'(-i_z) : qte_pkg::ZW'(i_z);
        sum    = (64'(r_p) << FRAC) + (64'd5 << 30);
        t_full = sum >> 30;
        prod   = 64'(r_t) * 64'h0000_0000_CCCC_CCCD;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_a <= (i_z < 0);
            r_p     <= 46'(mag) * 46'd573;
            r_neg_b <= r_neg_a;
            // clip: anything this large saturates the field anyway
            r_t     <= (t_full > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : t_full[31:0];
            r_neg_c <= r_neg_b;
            r_q     <= prod[63:35];   // divide by ten
        end
    end

    always_comb begin
        q_s = {1'b0, r_q};
        if (!r_neg_c && r_q > HI) begin
            o_angle = {1'b0, {(OUT_W - 1){1'b1}}};
        end else if (r_neg_c && r_q > HI + 29'd1) begin
            o_angle = {1'b1, {(OUT_W - 1){1'b0}}};
        end else if (r_neg_c) begin
            o_angle = OUT_W'(-q_s);
        end else begin
            o_angle = OUT_W'(q_s);
        end
    end
endmodule

FILE: sv/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// Top level: quaternion to Z-Y-X Euler angles, fully pipelined.
// Uses qte_pkg, qte_sqrt_cell, qte_cordic_cell, qte_scale.
//
// Usage
//   Input channel: i_valid / o_stall carry one quaternion beat (present flag
//   and four signed Q2.30 components). A beat with the flag clear is taken
//   and dropped; it produces no result.
//   Output channel: o_valid / i_stall carry pitch, roll, yaw (1/2^FRAC deg)
//   and the asin saturation flag.
//   Throughput: one beat per cycle while no stall holds the pipeline. From
//   acceptance to o_valid a beat passes the input registers, the 32-cell square
//   root chain, then the CORDIC cell chain and the scaling stages.
//   Stall: the whole pipeline advances together; when the output register
//   holds an untaken result and i_stall is high, every stage holds and
//   o_stall rises. The output register keeps its beat stable meanwhile.
//   Reset (synchronous, active low): all valid bits clear, no result pending;
//   payload registers keep whatever they held.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES   = qte_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_quat_present,
    input  logic signed [qte_pkg::QW-1:0]        i_quat_w,
    input  logic signed [qte_pkg::QW-1:0]        i_quat_x,
    input  logic signed [qte_pkg::QW-1:0]        i_quat_y,
    input  logic signed [qte_pkg::QW-1:0]        i_quat_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [qte_pkg::PITCH_W-1:0]   o_pitch_angle,
    output logic signed [qte_pkg::ROLL_W-1:0]    o_roll_angle,
    output logic signed [qte_pkg::YAW_W-1:0]     o_yaw_angle,
    output logic                                 o_asin_clamped
);
    localparam int SIDE_LEN = qte_pkg::SQRT_STEPS + 1;
    localparam int TAG_LEN  = SIDE_LEN + 1 + CORDIC_STAGES + 3;

    typedef struct packed {
        logic signed [31:0]            s;
        logic signed [qte_pkg::SW-1:0] rn;
        logic signed [qte_pkg::SW-1:0] rd;
        logic signed [qte_pkg::SW-1:0] yn;
        logic signed [qte_pkg::SW-1:0] yd;
    } t_side;

    typedef struct packed {
        logic valid;
        logic clamped;
    } t_tag;

    logic en;

    // input register
    logic                          r_v1;
    logic signed [qte_pkg::QW-1:0] r_w, r_x, r_y, r_z;
    // product register
    logic                          r_v2;
    logic signed [qte_pkg::PW-1:0] r_wy, r_xz, r_yz, r_wx, r_xx, r_yy, r_xy, r_wz, r_ww, r_zz;
    // sums register
    logic                          r_v3, r_c3;
    t_side                         r_s3;
    // comb sums
    logic signed [qte_pkg::SW-1:0] s_raw;
    logic signed [qte_pkg::SW-1:0] one_q30;
    t_side                         n_s3;
    logic                          n_c3;
    logic signed [63:0]            sq;

    t_side          r_side [SIDE_LEN];
    t_tag           r_tag  [TAG_LEN];
    qte_pkg::t_sqrt sqrt_d [qte_pkg::SQRT_STEPS + 1];
    qte_pkg::t_sqrt r_sq_in;

    qte_pkg::t_cord r_pre_p, r_pre_r, r_pre_y;
    qte_pkg::t_cord cp [CORDIC_STAGES + 1];
    qte_pkg::t_cord cr [CORDIC_STAGES + 1];
    qte_pkg::t_cord cy [CORDIC_STAGES + 1];

    logic signed [qte_pkg::PITCH_W-1:0] pitch_c;
    logic signed [qte_pkg::ROLL_W-1:0]  roll_c;
    logic signed [qte_pkg::YAW_W-1:0]   yaw_c;

    logic                                r_out_valid, r_out_clamped;
    logic signed [qte_pkg::PITCH_W-1:0] r_pitch;
    logic signed [qte_pkg::ROLL_W-1:0]  r_roll;
    logic signed [qte_pkg::YAW_W-1:0]   r_yaw;

    // advance everything unless a finished beat is waiting on a stalled receiver
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // stage 1: capture; drop beats without a quaternion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid && i_quat_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w <= i_quat_w;
            r_x <= i_quat_x;
            r_y <= i_quat_y;
            r_z <= i_quat_z;
        end
    end

    // stage 2: the ten Q30 products, one multiplier each
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wy <= qte_pkg::mul_q30(r_w, r_y);
            r_xz <= qte_pkg::mul_q30(r_x, r_z);
            r_yz <= qte_pkg::mul_q30(r_y, r_z);
            r_wx <= qte_pkg::mul_q30(r_w, r_x);
            r_xx <= qte_pkg::mul_q30(r_x, r_x);
            r_yy <= qte_pkg::mul_q30(r_y, r_y);
            r_xy <= qte_pkg::mul_q30(r_x, r_y);
            r_wz <= qte_pkg::mul_q30(r_w, r_z);
            r_ww <= qte_pkg::mul_q30(r_w, r_w);
            r_zz <= qte_pkg::mul_q30(r_z, r_z);
        end
    end

    // stage 3: numerators, denominators and the saturated asin argument
    always_comb begin
        one_q30 = qte_pkg::SW'(64'sd1 << 30);
        s_raw   = (qte_pkg::SW'(r_wy) - qte_pkg::SW'(r_xz)) <<< 1;
        n_c3    = 1'b0;
        n_s3.s  = s_raw[31:0];
        if (s_raw > one_q30) begin
            n_s3.s = 32'sd1073741824;
            n_c3   = 1'b1;
        end else if (s_raw < -one_q30) begin
            n_s3.s = -32'sd1073741824;
            n_c3   = 1'b1;
        end
        n_s3.rn = (qte_pkg::SW'(r_yz) + qte_pkg::SW'(r_wx)) <<< 1;
        n_s3.rd = one_q30 - (qte_pkg::SW'(r_xx) <<< 1) - (qte_pkg::SW'(r_yy) <<< 1);
        n_s3.yn = (qte_pkg::SW'(r_xy) + qte_pkg::SW'(r_wz)) <<< 1;
        n_s3.yd = qte_pkg::SW'(r_ww) + qte_pkg::SW'(r_xx)
                - qte_pkg::SW'(r_yy) - qte_pkg::SW'(r_zz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3 <= n_s3;
            r_c3 <= n_c3;
        end
    end

    // stage 4: radicand 1 - s^2 in Q60
    assign sq = r_s3.s * r_s3.s;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_in.v   <= (64'd1 << 60) - $unsigned(sq);
            r_sq_in.res <= '0;
        end
    end

    assign sqrt_d[0] = r_sq_in;

    // square root chain, one result bit per cell
    for (genvar k = 0; k < qte_pkg::SQRT_STEPS; k++) begin : g_sqrt
        qte_sqrt_cell #(.STEP(k)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (sqrt_d[k]),
            .o_q   (sqrt_d[k + 1])
        );
    end

    // carry s, roll and yaw operands alongside the square root
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r_s3;
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_side[k] <= r_side[k - 1];
            end
        end
    end

    // valid and clamp flag ride along the whole pipeline from stage 4
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAG_LEN; k++) begin
                r_tag[k] <= '0;
            end
        end else if (en) begin
            r_tag[0] <= '{valid: r_v3, clamped: r_c3};
            for (int k = 1; k < TAG_LEN; k++) begin
                r_tag[k] <= r_tag[k - 1];
            end
        end
    end

    // CORDIC set-up: fold to the right half-plane, catch zero numerators
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pre_p <= qte_pkg::cord_pre(qte_pkg::XW'(r_side[SIDE_LEN - 1].s),
                          $signed(qte_pkg::XW'(sqrt_d[qte_pkg::SQRT_STEPS].res[31:0])));
            r_pre_r <= qte_pkg::cord_pre(qte_pkg::XW'(r_side[SIDE_LEN - 1].rn),
                                         qte_pkg::XW'(r_side[SIDE_LEN - 1].rd));
            r_pre_y <= qte_pkg::cord_pre(qte_pkg::XW'(r_side[SIDE_LEN - 1].yn),
                                         qte_pkg::XW'(r_side[SIDE_LEN - 1].yd));
        end
    end

    assign cp[0] = r_pre_p;
    assign cr[0] = r_pre_r;
    assign cy[0] = r_pre_y;

    // three CORDIC chains side by side, one rotation per cell
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        qte_cordic_cell #(.STEP(k)) u_pitch (
            .i_clk (i_clk), .i_en (en), .i_d (cp[k]), .o_q (cp[k + 1])
        );
        qte_cordic_cell #(.STEP(k)) u_roll (
            .i_clk (i_clk), .i_en (en), .i_d (cr[k]), .o_q (cr[k + 1])
        );
        qte_cordic_cell #(.STEP(k)) u_yaw (
            .i_clk (i_clk), .i_en (en), .i_d (cy[k]), .o_q (cy[k + 1])
        );
    end

    // radians to degree units
    qte_scale #(.FRAC(ANGLE_FRAC_BITS), .OUT_W(qte_pkg::PITCH_W)) u_scale_pitch (
        .i_clk (i_clk), .i_en (en), .i_z (cp[CORDIC_STAGES].z), .o_angle (pitch_c)
    );
    qte_scale #(.FRAC(ANGLE_FRAC_BITS), .OUT_W(qte_pkg::ROLL_W)) u_scale_roll (
        .i_clk (i_clk), .i_en (en), .i_z (cr[CORDIC_STAGES].z), .o_angle (roll_c)
    );
    qte_scale #(.FRAC(ANGLE_FRAC_BITS), .OUT_W(qte_pkg::YAW_W)) u_scale_yaw (
        .i_clk (i_clk), .i_en (en), .i_z (cy[CORDIC_STAGES].z), .o_angle (yaw_c)
    );

    // output register: holds its beat while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_tag[TAG_LEN - 1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_clamped <= r_tag[TAG_LEN - 1].clamped;
            r_pitch       <= pitch_c;
            r_roll        <= roll_c;
            r_yaw         <= yaw_c;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_asin_clamped = r_out_clamped;
    assign o_pitch_angle  = r_pitch;
    assign o_roll_angle   = r_roll;
    assign o_yaw_angle    = r_yaw;

    // the pipeline only ever holds for a pending, untaken result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("pipeline held without a pending result");

    // square root of a Q60 value at most one stays within Q30 one
    a_sqrt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag[SIDE_LEN - 1].valid |-> (sqrt_d[qte_pkg::SQRT_STEPS].res[63:31] == '0))
        else $error("square root result out of range");

    // a clamp flag on a live beat reaches the output register with it
    a_clamp_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag[TAG_LEN - 1].clamped && r_tag[TAG_LEN - 1].valid && en |=>
            (o_valid && o_asin_clamped))
        else $error("clamp flag lost on the way out");

endmodule
